// File: rtl/mwm_pkg.sv
// Shared constants for the mecanum wheel mixer: default parameters, phase
// constants and the quarter-wave cosine table.
// No dependencies.
package mwm_pkg;

    localparam int CMD_LIMIT  = 127;
    localparam int ANGLE_BITS = 16;

    localparam int PHASE_BITS = 16;
    localparam int SPEED_W    = 16;
    localparam int CMD_W      = 8;
    localparam int COS_W      = 17;
    localparam int COS_SHIFT  = 15;
    localparam int SEG_BITS   = 10;
    localparam int WHEELS     = 4;

    localparam logic [PHASE_BITS-1:0] EIGHTH_TURN  = 16'h2000;
    localparam logic [14:0]           QUARTER_TURN = 15'h4000;

    localparam int COS_POINTS = 17;
    localparam logic [15:0] COS_TBL [0:COS_POINTS-1] = '{
        16'd32767, 16'd32610, 16'd32138, 16'd31357, 16'd30274, 16'd28899,
        16'd27246, 16'd25330, 16'd23170, 16'd20788, 16'd18205, 16'd15447,
        16'd12540, 16'd9512,  16'd6393,  16'd3212,  16'd0
    };

endpackage

// File: rtl/mwm_cos.sv
// Two-stage Q1.15 cosine of a 16-bit phase: quadrant fold and table lookup,
// then linear interpolation and sign. Depends on mwm_pkg.
module mwm_cos (
    input  logic                                i_clk,
    input  logic [mwm_pkg::PHASE_BITS-1:0]      i_phase,
    output logic signed [mwm_pkg::COS_W-1:0]    o_cos
);

    logic [14:0] arg;
    logic [4:0]  idx;
    logic [4:0]  nxt;
    logic [15:0] n_base;
    logic [11:0] n_diff;
    logic [15:0] diff_full;

    logic [15:0]                       r_base;
    logic [11:0]                       r_diff;
    logic [mwm_pkg::SEG_BITS-1:0]      r_frac;
    logic                              r_neg;
    logic signed [mwm_pkg::COS_W-1:0]  r_cos;

    logic [21:0]                       slope;
    logic [15:0]                       mag;

    // Quadrants one and three run the table backwards.
    always_comb begin
        if (i_phase[14]) begin
            arg = mwm_pkg::QUARTER_TURN - {1'b0, i_phase[13:0]};
        end else begin
            arg = {1'b0, i_phase[13:0]};
        end
        idx = arg[14:10];
        nxt = idx + 5'd1;
        diff_full = '0;
        if (idx == 5'd16) begin
            n_base = '0;
            n_diff = '0;
        end else begin
            n_base = mwm_pkg::COS_TBL[idx];
            diff_full = mwm_pkg::COS_TBL[idx] - mwm_pkg::COS_TBL[nxt];
            n_diff = diff_full[11:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_diff <= n_diff;
        r_frac <= arg[mwm_pkg::SEG_BITS-1:0];
        r_neg  <= i_phase[15] ^ i_phase[14];
    end

    assign slope = 22'(r_diff) * 22'(r_frac);
    assign mag   = r_base - 16'(slope >> mwm_pkg::SEG_BITS);

    always_ff @(posedge i_clk) begin
        if (r_neg) begin
            r_cos <= -$signed({1'b0, mag});
        end else begin
            r_cos <= $signed({1'b0, mag});
        end
    end

    assign o_cos = r_cos;

endmodule

// File: rtl/mwm_div.sv
// Pipelined restoring divider for the four wheel lanes, one quotient bit per
// stage, shared divisor. Depends on mwm_pkg.
module mwm_div #(
    parameter int NW = 15,
    parameter int DW = 8,
    parameter int QW = 7,
    parameter int SW = 5
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [mwm_pkg::WHEELS-1:0][NW-1:0]     i_num,
    input  logic [DW-1:0]                          i_den,
    input  logic [SW-1:0]                          i_side,
    output logic                                   o_valid,
    output logic [mwm_pkg::WHEELS-1:0][QW-1:0]     o_quo,
    output logic [SW-1:0]                          o_side
);

    localparam int RN = (QW > 1) ? QW - 1 : 1;

    logic                                  r_vld  [0:QW-1];
    logic [mwm_pkg::WHEELS-1:0][QW-1:0]    r_quo  [0:QW-1];
    logic [SW-1:0]                         r_side [0:QW-1];
    logic [mwm_pkg::WHEELS-1:0][NW-1:0]    r_rem  [0:RN-1];
    logic [DW-1:0]                         r_den  [0:RN-1];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;

        logic [mwm_pkg::WHEELS-1:0][NW-1:0] a_rem;
        logic [mwm_pkg::WHEELS-1:0][NW-1:0] n_rem;
        logic [mwm_pkg::WHEELS-1:0][QW-1:0] a_quo;
        logic [mwm_pkg::WHEELS-1:0][QW-1:0] n_quo;
        logic [DW-1:0]                      a_den;
        logic [SW-1:0]                      a_side;
        logic                               a_vld;
        logic [NW-1:0]                      den_sh;

        if (s == 0) begin : g_first
            assign a_rem  = i_num;
            assign a_quo  = '0;
            assign a_den  = i_den;
            assign a_side = i_side;
            assign a_vld  = i_valid;
        end else begin : g_next
            assign a_rem  = r_rem[s-1];
            assign a_quo  = r_quo[s-1];
            assign a_den  = r_den[s-1];
            assign a_side = r_side[s-1];
            assign a_vld  = r_vld[s-1];
        end

        assign den_sh = NW'(a_den) << B;

        always_comb begin
            n_rem = a_rem;
            n_quo = a_quo;
            for (int k = 0; k < mwm_pkg::WHEELS; k++) begin
                if (a_rem[k] >= den_sh) begin
                    n_rem[k]    = a_rem[k] - den_sh;
                    n_quo[k][B] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_quo[s]  <= n_quo;
            r_side[s] <= a_side;
        end

        // The last stage only needs its quotient bit, not the remainder.
        if (s < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[s] <= n_rem;
                r_den[s] <= a_den;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_quo[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

// File: rtl/mecanum_wheel_mixer_unit.sv
// Mecanum wheel mixer: heading, speed and rotation in, four scaled wheel
// commands out. Results pass through the cosine, multiply, mixing and max
// stages, one divider stage per quotient bit and an output register. A new
// transaction is taken every cycle; busy is high only during reset and the
// cycle after it. Reset clears all valid bits, so no result is issued for a
// transaction in flight when reset is applied.
module mecanum_wheel_mixer_unit #(
    parameter int CMD_LIMIT  = mwm_pkg::CMD_LIMIT,
    parameter int ANGLE_BITS = mwm_pkg::ANGLE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ANGLE_BITS-1:0]               i_heading_angle,
    input  logic signed [mwm_pkg::SPEED_W-1:0]  i_drive_speed,
    input  logic signed [mwm_pkg::SPEED_W-1:0]  i_turn_rate,
    input  logic                                i_no_ramp,
    output logic                                o_result_valid,
    output logic signed [mwm_pkg::CMD_W-1:0]    o_front_right_cmd,
    output logic signed [mwm_pkg::CMD_W-1:0]    o_rear_right_cmd,
    output logic signed [mwm_pkg::CMD_W-1:0]    o_front_left_cmd,
    output logic signed [mwm_pkg::CMD_W-1:0]    o_rear_left_cmd,
    output logic                                o_no_ramp_out
);

    localparam int LW  = $clog2(CMD_LIMIT + 1);
    localparam int MW  = LW + 1;
    localparam int WW  = LW + 2;
    localparam int PW  = LW + 1 + mwm_pkg::COS_W;
    localparam int NW  = MW + LW;
    localparam int SW  = mwm_pkg::WHEELS + 1;
    localparam int LAT = 7 + LW;
    localparam int NWH = mwm_pkg::WHEELS;

    function automatic logic signed [LW:0] clamp_cmd(input logic signed [15:0] v);
        logic signed [16:0] lim;
        logic signed [16:0] res;
        lim = 17'(CMD_LIMIT);
        if (v > lim) begin
            res = lim;
        end else if (v < -lim) begin
            res = -lim;
        end else begin
            res = 17'(v);
        end
        return (LW + 1)'(res);
    endfunction

    // Ready is registered and comes up in the cycle after reset is released.
    logic r_rdy;
    logic accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rdy <= 1'b0;
        end else begin
            r_rdy <= 1'b1;
        end
    end

    assign busy   = !r_rdy;
    assign accept = start && r_rdy;

    // Phase alignment and the two diagonal phases.
    logic [mwm_pkg::PHASE_BITS-1:0] phase;
    logic [mwm_pkg::PHASE_BITS-1:0] ph_r;
    logic [mwm_pkg::PHASE_BITS-1:0] ph_l;

    if (ANGLE_BITS >= mwm_pkg::PHASE_BITS) begin : g_phase_cut
        assign phase = i_heading_angle[ANGLE_BITS-1 -: mwm_pkg::PHASE_BITS];
    end else begin : g_phase_pad
        assign phase = {i_heading_angle, {(mwm_pkg::PHASE_BITS - ANGLE_BITS){1'b0}}};
    end

    assign ph_r = phase + mwm_pkg::EIGHTH_TURN;
    assign ph_l = phase - mwm_pkg::EIGHTH_TURN;

    logic signed [mwm_pkg::COS_W-1:0] cos_r;
    logic signed [mwm_pkg::COS_W-1:0] cos_l;

    mwm_cos u_cos_right (
        .i_clk   (i_clk),
        .i_phase (ph_r),
        .o_cos   (cos_r)
    );

    mwm_cos u_cos_left (
        .i_clk   (i_clk),
        .i_phase (ph_l),
        .o_cos   (cos_l)
    );

    // Stages 1 and 2: clamped speed and rotation ride alongside the cosine.
    logic               r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic signed [LW:0] r_spd1, r_spd2, r_rot1, r_rot2, r_rot3;
    logic               r_nr1, r_nr2, r_nr3, r_nr4, r_nr5, r_nr6;

    // Stage 3 products, stage 4 wheels, stage 5 magnitudes, stage 6 numerators.
    logic signed [PW-1:0] r_prod_r, r_prod_l;
    logic signed [WW-1:0] r_whl [0:NWH-1];
    logic [MW-1:0]        r_mag [0:NWH-1];
    logic [NWH-1:0]       r_sgn5, r_sgn6;
    logic [MW-1:0]        r_max, r_den;
    logic [NWH-1:0][NW-1:0] r_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        r_spd1 <= clamp_cmd(i_drive_speed);
        r_rot1 <= clamp_cmd(i_turn_rate);
        r_nr1  <= i_no_ramp;
        r_spd2 <= r_spd1;
        r_rot2 <= r_rot1;
        r_nr2  <= r_nr1;
        r_prod_r <= PW'(r_spd2) * PW'(cos_r);
        r_prod_l <= PW'(r_spd2) * PW'(cos_l);
        r_rot3 <= r_rot2;
        r_nr3  <= r_nr2;
    end

    // Stage 4: Q15 product truncated toward zero, then the rotation mix.
    logic [PW-1:0]      pa_r, pa_l;
    logic [LW-1:0]      dm_r, dm_l;
    logic signed [LW:0] diag_r, diag_l;

    always_comb begin
        pa_r = r_prod_r[PW-1] ? PW'(-r_prod_r) : PW'(r_prod_r);
        pa_l = r_prod_l[PW-1] ? PW'(-r_prod_l) : PW'(r_prod_l);
        dm_r = LW'(pa_r >> mwm_pkg::COS_SHIFT);
        dm_l = LW'(pa_l >> mwm_pkg::COS_SHIFT);
        diag_r = r_prod_r[PW-1] ? -$signed({1'b0, dm_r}) : $signed({1'b0, dm_r});
        diag_l = r_prod_l[PW-1] ? -$signed({1'b0, dm_l}) : $signed({1'b0, dm_l});
    end

    always_ff @(posedge i_clk) begin
        r_whl[0] <= WW'(diag_r) + WW'(r_rot3);
        r_whl[1] <= WW'(diag_l) + WW'(r_rot3);
        r_whl[2] <= WW'(diag_l) - WW'(r_rot3);
        r_whl[3] <= WW'(diag_r) - WW'(r_rot3);
        r_nr4    <= r_nr3;
    end

    // Stage 5: magnitudes and the largest one, never below the limit. Dividing
    // by the limit itself then leaves an unscaled wheel unchanged.
    logic [MW-1:0]  n_mag [0:NWH-1];
    logic [NWH-1:0] n_sgn;
    logic [MW-1:0]  m01, m23, m03, n_max;

    always_comb begin
        for (int k = 0; k < NWH; k++) begin
            n_sgn[k] = r_whl[k][WW-1];
            n_mag[k] = n_sgn[k] ? MW'(-r_whl[k]) : MW'(r_whl[k]);
        end
        m01   = (n_mag[0] > n_mag[1]) ? n_mag[0] : n_mag[1];
        m23   = (n_mag[2] > n_mag[3]) ? n_mag[2] : n_mag[3];
        m03   = (m01 > m23) ? m01 : m23;
        n_max = (m03 > MW'(CMD_LIMIT)) ? m03 : MW'(CMD_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NWH; k++) begin
            r_mag[k] <= n_mag[k];
        end
        r_sgn5 <= n_sgn;
        r_max  <= n_max;
        r_nr5  <= r_nr4;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NWH; k++) begin
            r_num[k] <= NW'(r_mag[k]) * NW'(CMD_LIMIT);
        end
        r_den  <= r_max;
        r_sgn6 <= r_sgn5;
        r_nr6  <= r_nr5;
    end

    logic                     dv_vld;
    logic [NWH-1:0][LW-1:0]   dv_quo;
    logic [SW-1:0]            dv_side;

    mwm_div #(
        .NW (NW),
        .DW (MW),
        .QW (LW),
        .SW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v6),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_side  ({r_sgn6, r_nr6}),
        .o_valid (dv_vld),
        .o_quo   (dv_quo),
        .o_side  (dv_side)
    );

    // Output stage: restore signs and fit the command width.
    logic signed [LW:0]               res [0:NWH-1];
    logic signed [mwm_pkg::CMD_W-1:0] r_cmd [0:NWH-1];
    logic                             r_ovld;
    logic                             r_onr;

    always_comb begin
        for (int k = 0; k < NWH; k++) begin
            if (dv_side[k + 1]) begin
                res[k] = -$signed({1'b0, dv_quo[k]});
            end else begin
                res[k] = $signed({1'b0, dv_quo[k]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else begin
            r_ovld <= dv_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NWH; k++) begin
            r_cmd[k] <= mwm_pkg::CMD_W'(res[k]);
        end
        r_onr <= dv_side[0];
    end

    assign o_result_valid    = r_ovld;
    assign o_front_right_cmd = r_cmd[0];
    assign o_rear_right_cmd  = r_cmd[1];
    assign o_front_left_cmd  = r_cmd[2];
    assign o_rear_left_cmd   = r_cmd[3];
    assign o_no_ramp_out     = r_onr;

    // Every accepted transaction produces its result a fixed time later.
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_result_valid)
        else $error("result strobe missing after fixed latency");

    // A result is never issued without a transaction behind it.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(accept, LAT))
        else $error("result strobe without an accepted transaction");

    // Scaling never pushes a wheel past the limit.
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_vld |-> (dv_quo[0] <= CMD_LIMIT && dv_quo[1] <= CMD_LIMIT &&
                    dv_quo[2] <= CMD_LIMIT && dv_quo[3] <= CMD_LIMIT))
        else $error("wheel command magnitude above limit");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for mecanum_wheel_mixer_unit: a directed table, then random commands
// with random start gaps, each result checked against a hand value or a kinematics predictor.
// Depends on rtl/mwm_pkg.sv and rtl/mecanum_wheel_mixer_unit.sv.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [mwm_pkg::CMD_W-1:0] front_right;
        logic signed [mwm_pkg::CMD_W-1:0] rear_right;
        logic signed [mwm_pkg::CMD_W-1:0] front_left;
        logic signed [mwm_pkg::CMD_W-1:0] rear_left;
        logic                             no_ramp;
    } wheel_cmd_t;

    typedef struct packed {
        logic [mwm_pkg::PHASE_BITS-1:0]     heading;
        logic signed [mwm_pkg::SPEED_W-1:0] speed;
        logic signed [mwm_pkg::SPEED_W-1:0] turn;
        logic                               no_ramp;
        logic                               known;
        wheel_cmd_t                         cmd;
    } drive_row_t;

    localparam int N_DIRECTED   = 22;
    localparam int N_RANDOM     = 1230;
    localparam int N_CALM_TAIL  = 150;
    localparam int DRAIN_CYCLES = 24;
    localparam int WATCHDOG     = 1000;

    // Rows with known set carry a result worked out by hand; the rest go to the predictor.
    localparam drive_row_t DIRECTED [N_DIRECTED] = '{
        '{16'h0000, 16'sd0,      16'sd0,      1'b0, 1'b1, '{8'sd0, 8'sd0, 8'sd0, 8'sd0, 1'b0}},
        '{16'h0000, 16'sd127,    16'sd0,      1'b1, 1'b1,
          '{8'sd89, 8'sd89, 8'sd89, 8'sd89, 1'b1}},
        '{16'h0000, 16'sd0,      16'sd127,    1'b0, 1'b1,
          '{8'sd127, 8'sd127, -8'sd127, -8'sd127, 1'b0}},
        '{16'h0000, 16'sd0,      -16'sd32768, 1'b1, 1'b1,
          '{-8'sd127, -8'sd127, 8'sd127, 8'sd127, 1'b1}},
        '{16'h0000, 16'sd32767,  16'sd32767,  1'b0, 1'b1,
          '{8'sd127, 8'sd127, -8'sd22, -8'sd22, 1'b0}},
        '{16'h4000, 16'sd127,    16'sd0,      1'b0, 1'b1,
          '{-8'sd89, 8'sd89, 8'sd89, -8'sd89, 1'b0}},
        '{16'h0000, -16'sd32768, 16'sd0,      1'b0, 1'b1,
          '{-8'sd89, -8'sd89, -8'sd89, -8'sd89, 1'b0}},
        '{16'hFFFF, 16'sd127,    16'sd0,      1'b0, 1'b0, '0},
        '{16'h8000, 16'sd127,    16'sd0,      1'b1, 1'b0, '0},
        '{16'hC000, -16'sd127,   16'sd5,      1'b0, 1'b0, '0},
        '{16'h2000, 16'sd127,    16'sd127,    1'b1, 1'b0, '0},
        '{16'h6000, 16'sd100,    -16'sd100,   1'b0, 1'b0, '0},
        '{16'h0400, 16'sd50,     -16'sd3,     1'b0, 1'b0, '0},
        '{16'h03FF, 16'sd127,    -16'sd127,   1'b1, 1'b0, '0},
        '{16'hE000, -16'sd127,   16'sd127,    1'b0, 1'b0, '0},
        '{16'h1234, 16'sd128,    -16'sd128,   1'b1, 1'b0, '0},
        '{16'hABCD, -16'sd129,   16'sd129,    1'b0, 1'b0, '0},
        '{16'h7FFF, 16'sd32767,  -16'sd32768, 1'b1, 1'b0, '0},
        '{16'h0001, 16'sd1,      -16'sd1,     1'b0, 1'b0, '0},
        '{16'hA000, -16'sd1,     16'sd1,      1'b1, 1'b0, '0},
        '{16'h5555, -16'sd60,    16'sd90,     1'b0, 1'b0, '0},
        '{16'hAAAA, 16'sd127,    16'sd127,    1'b1, 1'b0, '0}
    };

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic [mwm_pkg::ANGLE_BITS-1:0]     i_heading_angle;
    logic signed [mwm_pkg::SPEED_W-1:0] i_drive_speed;
    logic signed [mwm_pkg::SPEED_W-1:0] i_turn_rate;
    logic                               i_no_ramp;
    logic                               o_result_valid;
    logic signed [mwm_pkg::CMD_W-1:0]   o_front_right_cmd;
    logic signed [mwm_pkg::CMD_W-1:0]   o_rear_right_cmd;
    logic signed [mwm_pkg::CMD_W-1:0]   o_front_left_cmd;
    logic signed [mwm_pkg::CMD_W-1:0]   o_rear_left_cmd;
    logic                               o_no_ramp_out;

    // Hand-worked result for the command currently on the inputs, if there is one.
    logic       hand_known;
    wheel_cmd_t hand_cmd;

    wheel_cmd_t pending_cmds[$];
    int         error_count = 0;
    int         quiet_cycles = 0;

    mecanum_wheel_mixer_unit i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_heading_angle   (i_heading_angle),
        .i_drive_speed     (i_drive_speed),
        .i_turn_rate       (i_turn_rate),
        .i_no_ramp         (i_no_ramp),
        .o_result_valid    (o_result_valid),
        .o_front_right_cmd (o_front_right_cmd),
        .o_rear_right_cmd  (o_rear_right_cmd),
        .o_front_left_cmd  (o_front_left_cmd),
        .o_rear_left_cmd   (o_rear_left_cmd),
        .o_no_ramp_out     (o_no_ramp_out)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Cosine over the first quadrant, q from 0 to a full quarter turn inclusive.
    function automatic int quadrant_cos(int unsigned q);
        int unsigned seg;
        int unsigned frac;
        int unsigned drop;
        seg  = q >> mwm_pkg::SEG_BITS;
        frac = q & 1023;
        if (seg >= mwm_pkg::COS_POINTS - 1) begin
            return 0;
        end
        drop = int'(mwm_pkg::COS_TBL[seg]) - int'(mwm_pkg::COS_TBL[seg + 1]);
        return int'(mwm_pkg::COS_TBL[seg]) - int'((drop * frac) >> mwm_pkg::SEG_BITS);
    endfunction

    function automatic int phase_cos(logic [mwm_pkg::PHASE_BITS-1:0] p);
        int unsigned q;
        q = p[13:0];
        case (p[15:14])
            2'd0:    return quadrant_cos(q);
            2'd1:    return -quadrant_cos(32'h4000 - q);
            2'd2:    return -quadrant_cos(q);
            default: return quadrant_cos(32'h4000 - q);
        endcase
    endfunction

    function automatic int clamp_cmd(logic signed [mwm_pkg::SPEED_W-1:0] v);
        int x;
        x = v;
        if (x > mwm_pkg::CMD_LIMIT) begin
            return mwm_pkg::CMD_LIMIT;
        end
        if (x < -mwm_pkg::CMD_LIMIT) begin
            return -mwm_pkg::CMD_LIMIT;
        end
        return x;
    endfunction

    // Speed times a Q1.15 cosine, truncated toward zero.
    function automatic int diag_term(int spd, int c);
        int prod;
        prod = spd * c;
        if (prod < 0) begin
            return -((-prod) >>> mwm_pkg::COS_SHIFT);
        end
        return prod >>> mwm_pkg::COS_SHIFT;
    endfunction

    function automatic wheel_cmd_t mix_wheels(logic [mwm_pkg::PHASE_BITS-1:0] heading,
                                              logic signed [mwm_pkg::SPEED_W-1:0] speed,
                                              logic signed [mwm_pkg::SPEED_W-1:0] turn,
                                              logic ramp);
        int         spd;
        int         rot;
        int         right_diag;
        int         left_diag;
        int         peak;
        int         w[mwm_pkg::WHEELS];
        logic [mwm_pkg::PHASE_BITS-1:0] ahead;
        logic [mwm_pkg::PHASE_BITS-1:0] behind;
        wheel_cmd_t r;
        spd    = clamp_cmd(speed);
        rot    = clamp_cmd(turn);
        ahead  = heading + mwm_pkg::EIGHTH_TURN;
        behind = heading - mwm_pkg::EIGHTH_TURN;
        right_diag = diag_term(spd, phase_cos(ahead));
        left_diag  = diag_term(spd, phase_cos(behind));
        w[0] = right_diag + rot;
        w[1] = left_diag + rot;
        w[2] = left_diag - rot;
        w[3] = right_diag - rot;
        peak = mwm_pkg::CMD_LIMIT;
        for (int k = 0; k < mwm_pkg::WHEELS; k++) begin
            if ((w[k] < 0 ? -w[k] : w[k]) > peak) begin
                peak = w[k] < 0 ? -w[k] : w[k];
            end
        end
        // Signed division in SystemVerilog truncates toward zero, as required.
        if (peak > mwm_pkg::CMD_LIMIT) begin
            for (int k = 0; k < mwm_pkg::WHEELS; k++) begin
                w[k] = (w[k] * mwm_pkg::CMD_LIMIT) / peak;
            end
        end
        r.front_right = 8'(w[0]);
        r.rear_right  = 8'(w[1]);
        r.front_left  = 8'(w[2]);
        r.rear_left   = 8'(w[3]);
        r.no_ramp     = ramp;
        return r;
    endfunction

    // Mostly in-range rates, some around the clamp point, some anywhere in 16 bits.
    function automatic logic signed [mwm_pkg::SPEED_W-1:0] random_rate();
        int unsigned pick;
        int          mag;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return mwm_pkg::SPEED_W'($urandom_range(0, 2 * mwm_pkg::CMD_LIMIT)
                                     - mwm_pkg::CMD_LIMIT);
        end
        if (pick < 8) begin
            mag = $urandom_range(mwm_pkg::CMD_LIMIT - 8, mwm_pkg::CMD_LIMIT + 12);
            return mwm_pkg::SPEED_W'($urandom_range(0, 1) ? mag : -mag);
        end
        return mwm_pkg::SPEED_W'($urandom);
    endfunction

    task automatic drive_cmd(drive_row_t row);
        @(negedge i_clk);
        start           <= 1'b1;
        i_heading_angle <= row.heading;
        i_drive_speed   <= row.speed;
        i_turn_rate     <= row.turn;
        i_no_ramp       <= row.no_ramp;
        hand_known      <= row.known;
        hand_cmd        <= row.cmd;
        // Busy only moves at rising edges, so the value seen here is what the next edge sees.
        while (busy) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    // Drops start for a burst of cycles and puts junk on the command fields meanwhile.
    task automatic idle_burst(int cycles);
        for (int n = 0; n < cycles; n++) begin
            @(negedge i_clk);
            start           <= 1'b0;
            i_heading_angle <= mwm_pkg::ANGLE_BITS'($urandom);
            i_drive_speed   <= mwm_pkg::SPEED_W'($urandom);
            i_turn_rate     <= mwm_pkg::SPEED_W'($urandom);
            i_no_ramp       <= 1'($urandom);
        end
    endtask

    // Acceptance and checking share one process, so the expectation of a transaction is
    // always queued before any result is taken off the queue in the same cycle.
    always @(posedge i_clk) begin
        wheel_cmd_t want;
        if (i_rst_n) begin
            if (start && !busy) begin
                pending_cmds.push_back(hand_known ? hand_cmd
                    : mix_wheels(i_heading_angle, i_drive_speed, i_turn_rate, i_no_ramp));
            end
            if (o_result_valid) begin
                if (pending_cmds.size() == 0) begin
                    $error("result with no command outstanding");
                    error_count++;
                end else begin
                    want = pending_cmds.pop_front();
                    if (o_front_right_cmd !== want.front_right) begin
                        $error("front_right_cmd: expected %0d, got %0d",
                               want.front_right, o_front_right_cmd);
                        error_count++;
                    end
                    if (o_rear_right_cmd !== want.rear_right) begin
                        $error("rear_right_cmd: expected %0d, got %0d",
                               want.rear_right, o_rear_right_cmd);
                        error_count++;
                    end
                    if (o_front_left_cmd !== want.front_left) begin
                        $error("front_left_cmd: expected %0d, got %0d",
                               want.front_left, o_front_left_cmd);
                        error_count++;
                    end
                    if (o_rear_left_cmd !== want.rear_left) begin
                        $error("rear_left_cmd: expected %0d, got %0d",
                               want.rear_left, o_rear_left_cmd);
                        error_count++;
                    end
                    if (o_no_ramp_out !== want.no_ramp) begin
                        $error("no_ramp_out: expected %0d, got %0d",
                               want.no_ramp, o_no_ramp_out);
                        error_count++;
                    end
                end
            end
            if ((start && !busy) || o_result_valid) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        drive_row_t row;
        int unsigned pick;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_heading_angle = '0;
        i_drive_speed   = '0;
        i_turn_rate     = '0;
        i_no_ramp       = 1'b0;
        hand_known      = 1'b0;
        hand_cmd        = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            drive_cmd(DIRECTED[i]);
            if ($urandom_range(0, 3) == 0) begin
                idle_burst($urandom_range(1, 14));
            end
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            pick = $urandom_range(0, 3);
            // Some headings sit on or next to a table point to hit the interpolation ends.
            if (pick == 0) begin
                row.heading = mwm_pkg::PHASE_BITS'(($urandom_range(0, 63) << mwm_pkg::SEG_BITS)
                                                   + $urandom_range(0, 2) - 1);
            end else begin
                row.heading = mwm_pkg::PHASE_BITS'($urandom);
            end
            row.speed   = random_rate();
            row.turn    = random_rate();
            row.no_ramp = 1'($urandom);
            row.known   = 1'b0;
            row.cmd     = '0;
            drive_cmd(row);
            if (i < N_RANDOM - N_CALM_TAIL && $urandom_range(0, 3) == 0) begin
                idle_burst($urandom_range(1, 14));
            end
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_cmds.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_cmds.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/mwm_pkg.sv
rtl/mwm_cos.sv
rtl/mwm_div.sv
rtl/mecanum_wheel_mixer_unit.sv
dv/testbench.sv
